@@ sv/rsh_pkg.sv @@
// Shared types and constants for the ray/sphere hit test pipeline.
package rsh_pkg;

    // Cycles from an accepted start to the matching done strobe.
    localparam int RSH_LATENCY = 7;

    // Per-item control that travels alongside the payload.
    typedef struct packed {
        logic valid;    // stage holds a live item
        logic enclosed; // origin inside or on the sphere
        logic far;      // length limit rejects the item
        logic dot_neg;  // offset . direction is negative
    } rsh_ctl_t;

endpackage

@@ sv/ray_sphere_hit_test_top.sv @@
// Top level of the pipelined ray/sphere hit test.
//
// One ray/sphere pair is taken per start pulse and answered with one hit bit.
// The block takes a new item in every cycle: busy is always low, and each
// item's done strobe is raised by the final register stage, in the order
// taken. The receiver cannot stall, so results are held for one cycle only
// and must be captured on the done strobe. The stage chain is: offset,
// products, sums, inside/limit tests, a two-stage square of the wide dot
// product, and the final compare. All arithmetic is exact fixed point with
// FRAC_BITS fraction bits; nothing rounds or clips.
module ray_sphere_hit_test_top
    import rsh_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [COORD_WIDTH-2:0] radius,
    input  logic        [COORD_WIDTH-2:0] max_length,
    input  logic                          limit_enable,
    output logic                          hit,
    output logic                          done
);

    localparam int W    = COORD_WIDTH;
    localparam int VW   = W + 1;          // origin - center
    localparam int PW   = 2 * W;          // one square or one dot term
    localparam int SUMW = 2 * W + 2;      // |v|^2 and c
    localparam int DOTW = 2 * W + 2;      // v . dir, signed
    localparam int FW   = 2 * W + 1;      // magnitude of a negative v . dir
    localparam int R2W  = 2 * W - 2;      // radius^2
    localparam int BW   = 2 * W;          // (2r + max_length) * max_length
    localparam int TW   = 2 * W + 1;      // r^2 + bound
    localparam int CSW  = SUMW + 2 * FRAC_BITS;
    localparam int CMPW = (2 * FW > CSW) ? 2 * FW : CSW;

    // Gather the axes into lanes.
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    logic signed [W-1:0] ctr [3];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;
    assign ctr[0] = center_x;
    assign ctr[1] = center_y;
    assign ctr[2] = center_z;

    // The pipeline never stalls: every start is a transfer.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // Stage 1: offset v = origin - center, span = 2r + max_length
    // ---------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic signed [VW-1:0] s1_v_next   [3];
    logic signed [VW-1:0] s1_v_reg    [3];
    logic signed [W-1:0]  s1_dir_reg  [3];
    logic        [W:0]    s1_span_next;
    logic        [W:0]    s1_span_reg;
    logic        [W-2:0]  s1_rad_reg;
    logic        [W-2:0]  s1_mlen_reg;
    logic                 s1_lim_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_v_next[k] = {org[k][W-1], org[k]} - {ctr[k][W-1], ctr[k]};
        end
    end

    assign s1_span_next = {1'b0, radius, 1'b0} + {2'b00, max_length};

    // ---------------------------------------------------------------------
    // Stage 2: squares, dot terms, r^2 and the length bound
    // ---------------------------------------------------------------------
    logic                   s2_valid_reg;
    logic signed [2*VW-1:0] s2_sq_full   [3];
    logic signed [VW+W-1:0] s2_pr_full   [3];
    logic        [PW-1:0]   s2_sq_reg    [3];
    logic signed [PW-1:0]   s2_pr_reg    [3];
    logic        [R2W-1:0]  s2_r2_next;
    logic        [R2W-1:0]  s2_r2_reg;
    logic        [BW-1:0]   s2_bound_next;
    logic        [BW-1:0]   s2_bound_reg;
    logic                   s2_lim_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_sq_full[k] = s1_v_reg[k] * s1_v_reg[k];
            s2_pr_full[k] = s1_v_reg[k] * s1_dir_reg[k];
        end
    end

    assign s2_r2_next    = s1_rad_reg * s1_rad_reg;
    assign s2_bound_next = s1_span_reg * s1_mlen_reg;

    // ---------------------------------------------------------------------
    // Stage 3: |v|^2, v . dir, and r^2 + bound for the limit test
    // ---------------------------------------------------------------------
    logic                   s3_valid_reg;
    logic        [SUMW-1:0] s3_sum_next;
    logic        [SUMW-1:0] s3_sum_reg;
    logic signed [DOTW-1:0] s3_dot_next;
    logic signed [DOTW-1:0] s3_dot_reg;
    logic        [TW-1:0]   s3_thresh_next;
    logic        [TW-1:0]   s3_thresh_reg;
    logic        [R2W-1:0]  s3_r2_reg;
    logic                   s3_lim_reg;

    assign s3_sum_next = {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]}
                       + {2'b00, s2_sq_reg[2]};
    assign s3_dot_next = {{2{s2_pr_reg[0][PW-1]}}, s2_pr_reg[0]}
                       + {{2{s2_pr_reg[1][PW-1]}}, s2_pr_reg[1]}
                       + {{2{s2_pr_reg[2][PW-1]}}, s2_pr_reg[2]};
    assign s3_thresh_next = {3'b000, s2_r2_reg} + {1'b0, s2_bound_reg};

    // ---------------------------------------------------------------------
    // Stage 4: inside test, limit test, c = |v|^2 - r^2, |v . dir|
    // ---------------------------------------------------------------------
    rsh_ctl_t               s4_ctl_next;
    rsh_ctl_t               s4_ctl_reg;
    logic        [SUMW-1:0] s4_c_next;
    logic        [SUMW-1:0] s4_c_reg;
    logic signed [DOTW-1:0] s4_neg_dot;
    logic        [FW-1:0]   s4_f_reg;

    // c > bound is the same as |v|^2 > r^2 + bound, so no subtract first.
    assign s4_ctl_next.valid    = s3_valid_reg;
    assign s4_ctl_next.enclosed = (s3_sum_reg <= {4'b0000, s3_r2_reg});
    assign s4_ctl_next.far      = s3_lim_reg && (s3_sum_reg > {1'b0, s3_thresh_reg});
    assign s4_ctl_next.dot_neg  = s3_dot_reg[DOTW-1];
    assign s4_c_next            = s3_sum_reg - {4'b0000, s3_r2_reg};
    assign s4_neg_dot           = -s3_dot_reg;

    // ---------------------------------------------------------------------
    // Stages 5 and 6: square of |v . dir|, with c held alongside
    // ---------------------------------------------------------------------
    rsh_ctl_t              s6_ctl;
    logic [2*FW-1:0]       s6_f2;
    logic [SUMW-1:0]       s5_c_reg;
    logic [SUMW-1:0]       s6_c_reg;

    rsh_wide_square #(
        .WIDTH (FW)
    ) u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (s4_ctl_reg),
        .operand (s4_f_reg),
        .ctl_out (s6_ctl),
        .square  (s6_f2)
    );

    // ---------------------------------------------------------------------
    // Stage 7: final decision; hit when inside, or when the ray points at
    // the sphere, passes the limit test and (v . dir)^2 >= c.
    // ---------------------------------------------------------------------
    logic [CMPW-1:0] s7_f2_ext;
    logic [CMPW-1:0] s7_cs_ext;
    logic            hit_next;
    logic            hit_reg;
    logic            done_reg;

    assign s7_f2_ext = CMPW'(s6_f2);
    assign s7_cs_ext = CMPW'(s6_c_reg) << (2 * FRAC_BITS);
    assign hit_next  = s6_ctl.enclosed
                    || (!s6_ctl.far && s6_ctl.dot_neg && (s7_f2_ext >= s7_cs_ext));

    // Valid bits: advance every cycle, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_ctl_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_ctl_reg   <= s4_ctl_next;
            done_reg     <= s6_ctl.valid;
        end
    end

    // Payload: no reset, advance every cycle.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_v_reg[k]   <= s1_v_next[k];
            s1_dir_reg[k] <= dir[k];
            s2_sq_reg[k]  <= s2_sq_full[k][PW-1:0];
            s2_pr_reg[k]  <= s2_pr_full[k][PW-1:0];
        end
        s1_span_reg   <= s1_span_next;
        s1_rad_reg    <= radius;
        s1_mlen_reg   <= max_length;
        s1_lim_reg    <= limit_enable;
        s2_r2_reg     <= s2_r2_next;
        s2_bound_reg  <= s2_bound_next;
        s2_lim_reg    <= s1_lim_reg;
        s3_sum_reg    <= s3_sum_next;
        s3_dot_reg    <= s3_dot_next;
        s3_thresh_reg <= s3_thresh_next;
        s3_r2_reg     <= s2_r2_reg;
        s3_lim_reg    <= s2_lim_reg;
        s4_c_reg      <= s4_c_next;
        s4_f_reg      <= s4_neg_dot[FW-1:0];
        s5_c_reg      <= s4_c_reg;
        s6_c_reg      <= s5_c_reg;
        hit_reg       <= hit_next;
    end

    assign hit  = hit_reg;
    assign done = done_reg;

endmodule

@@ sv/rsh_wide_square.sv @@
// Two-stage squarer for a wide unsigned operand, built from half-width products.
module rsh_wide_square
    import rsh_pkg::*;
#(
    parameter int WIDTH = 65
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsh_ctl_t             ctl_in,
    input  logic [WIDTH-1:0]     operand,
    output rsh_ctl_t             ctl_out,
    output logic [2*WIDTH-1:0]   square
);

    localparam int LO = (WIDTH + 1) / 2;
    localparam int HI = WIDTH - LO;
    localparam int SW = 2 * WIDTH;

    logic [HI-1:0]      op_hi;
    logic [LO-1:0]      op_lo;
    logic [2*HI-1:0]    hh_next;
    logic [HI+LO-1:0]   hl_next;
    logic [2*LO-1:0]    ll_next;
    logic [2*HI-1:0]    hh_reg;
    logic [HI+LO-1:0]   hl_reg;
    logic [2*LO-1:0]    ll_reg;
    logic [SW-1:0]      square_next;
    logic [SW-1:0]      square_reg;
    rsh_ctl_t           ctl_mid_reg;
    rsh_ctl_t           ctl_out_reg;

    assign op_hi   = operand[WIDTH-1:LO];
    assign op_lo   = operand[LO-1:0];
    assign hh_next = op_hi * op_hi;
    assign hl_next = op_hi * op_lo;
    assign ll_next = op_lo * op_lo;

    // hi^2 * 2^(2LO) + 2 * hi * lo * 2^LO + lo^2
    assign square_next = (SW'(hh_reg) << (2 * LO))
                       + (SW'(hl_reg) << (LO + 1))
                       + SW'(ll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_mid_reg <= '0;
            ctl_out_reg <= '0;
        end
        else
        begin
            ctl_mid_reg <= ctl_in;
            ctl_out_reg <= ctl_mid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hh_reg     <= hh_next;
        hl_reg     <= hl_next;
        ll_reg     <= ll_next;
        square_reg <= square_next;
    end

    assign ctl_out = ctl_out_reg;
    assign square  = square_reg;

endmodule

@@ sv/rsh_checker.sv @@
// Port-level checker for the ray/sphere hit test, bound to the top level.
module rsh_checker
    import rsh_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] origin_x,
    input logic signed [COORD_WIDTH-1:0] origin_y,
    input logic signed [COORD_WIDTH-1:0] origin_z,
    input logic signed [COORD_WIDTH-1:0] dir_x,
    input logic signed [COORD_WIDTH-1:0] dir_y,
    input logic signed [COORD_WIDTH-1:0] dir_z,
    input logic signed [COORD_WIDTH-1:0] center_x,
    input logic signed [COORD_WIDTH-1:0] center_y,
    input logic signed [COORD_WIDTH-1:0] center_z,
    input logic        [COORD_WIDTH-2:0] radius,
    input logic                          hit,
    input logic                          done
);

    // Every transfer produces its strobe after the fixed latency.
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##RSH_LATENCY done)
        else $error("accepted item produced no done strobe");

    // No strobe without a transfer the fixed latency earlier.
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, RSH_LATENCY))
        else $error("done strobe without a matching transfer");

    // Origin at the center is always inside.
    a_center_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && origin_x == center_x && origin_y == center_y
         && origin_z == center_z) |-> ##RSH_LATENCY hit)
        else $error("origin at the center did not hit");

    // Zero direction against a point sphere away from the origin misses.
    a_zero_dir_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && dir_x == '0 && dir_y == '0 && dir_z == '0
         && radius == '0 && (origin_x != center_x || origin_y != center_y
         || origin_z != center_z)) |-> ##RSH_LATENCY !hit)
        else $error("zero direction outside the sphere reported a hit");

endmodule

bind ray_sphere_hit_test_top rsh_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_rsh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius),
    .hit      (hit),
    .done     (done)
);

@@ sim/ray_sphere_hit_test_top_test.sv @@
// Self-checking testbench for the pipelined ray/sphere hit test.
module ray_sphere_hit_test_top_test
    import rsh_pkg::*;
();

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    // Cycles with neither a transfer nor a result before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_RAYS = 600;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MIN_NEG = 32'h8000_0000;

    // One ray/sphere pair as it sits on the input ports.
    typedef struct {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic        [COORD_WIDTH-2:0] radius;
        logic        [COORD_WIDTH-2:0] max_length;
        logic                          limit_enable;
    } ray_item_t;

    // Predicts the hit bit of every transferred ray and holds the answers
    // in transfer order until the done strobe brings the block's answer.
    class hit_scoreboard;
        bit expected_hits[$];
        int mismatches;
        int results_seen;

        // Exact integer evaluation; 200 bits covers the square of the dot
        // product (under 2^131) with plenty of margin.
        function bit predict_hit(ray_item_t r);
            logic signed [199:0] vx, vy, vz, dx, dy, dz;
            logic signed [199:0] rad_w, len_w, sq_sum, rad_sq, gap, bound, dot;
            vx = r.origin_x;
            vx = vx - r.center_x;
            vy = r.origin_y;
            vy = vy - r.center_y;
            vz = r.origin_z;
            vz = vz - r.center_z;
            dx = r.dir_x;
            dy = r.dir_y;
            dz = r.dir_z;
            rad_w = {169'b0, r.radius};
            len_w = {169'b0, r.max_length};
            sq_sum = vx * vx + vy * vy + vz * vz;
            rad_sq = rad_w * rad_w;
            // origin inside or on the surface
            if (sq_sum <= rad_sq)
                return 1'b1;
            gap = sq_sum - rad_sq;
            if (r.limit_enable)
            begin
                bound = (2 * rad_w + len_w) * len_w;
                if (gap > bound)
                    return 1'b0;
            end
            dot = vx * dx + vy * dy + vz * dz;
            // pointing away or sideways
            if (dot >= 0)
                return 1'b0;
            return (dot * dot) >= (gap <<< (2 * FRAC_BITS));
        endfunction

        function void note_transfer(ray_item_t r);
            expected_hits.push_back(predict_hit(r));
        endfunction

        function void check_result(logic got);
            bit want;
            results_seen++;
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("result %0d arrived with no ray pending, hit=%0b",
                             results_seen, got);
                return;
            end
            want = expected_hits.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("result %0d: expected hit=%0b, got hit=%0b",
                             results_seen, want, got);
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      hit;
    logic      done;
    ray_item_t on_bus;
    int        stall_cycles;

    hit_scoreboard sb = new;

    ray_sphere_hit_test_top #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .origin_x     (on_bus.origin_x),
        .origin_y     (on_bus.origin_y),
        .origin_z     (on_bus.origin_z),
        .dir_x        (on_bus.dir_x),
        .dir_y        (on_bus.dir_y),
        .dir_z        (on_bus.dir_z),
        .center_x     (on_bus.center_x),
        .center_y     (on_bus.center_y),
        .center_z     (on_bus.center_z),
        .radius       (on_bus.radius),
        .max_length   (on_bus.max_length),
        .limit_enable (on_bus.limit_enable),
        .hit          (hit),
        .done         (done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sample both sides at the rising edge, before this edge's updates land:
    // a transfer is start high with busy low, a result is the done strobe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_transfer(on_bus);
            if (done)
                sb.check_result(hit);
        end
    end

    // Watchdog: count edges with neither an input transfer nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic ray_item_t ray_of(
        logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
        logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
        logic [31:0] rad, logic [31:0] len, logic lim);
        ray_item_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        r.center_x = cx;
        r.center_y = cy;
        r.center_z = cz;
        r.radius = rad[30:0];
        r.max_length = len[30:0];
        r.limit_enable = lim;
        return r;
    endfunction

    // Mostly well-formed scenes: a fifth pure noise over every bit, some
    // origins inside the sphere, and the rest rays aimed near the center
    // with jitter, a random length scale and some pointing away.
    function automatic ray_item_t random_ray();
        ray_item_t r;
        int        sel, sh, k;
        int        cent[3];
        longint    off[3], dv[3];
        longint    m, a, scale;
        sel = $urandom_range(99);
        if (sel < 20)
            return ray_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(1)));
        sh = $urandom_range(2, 24);
        m = 0;
        for (k = 0; k < 3; k++)
        begin
            cent[k] = $signed($urandom) >>> 2;
            off[k] = longint'($signed($urandom)) >>> sh;
            a = (off[k] < 0) ? -off[k] : off[k];
            if (a > m)
                m = a;
        end
        if (sel < 35)
        begin
            // radius 2m always exceeds the offset length (at most sqrt(3) m)
            for (k = 0; k < 3; k++)
                dv[k] = longint'($signed($urandom)) >>> $urandom_range(0, 20);
            r = ray_of(cent[0] + 32'(off[0]), cent[1] + 32'(off[1]),
                       cent[2] + 32'(off[2]), 32'(dv[0]), 32'(dv[1]), 32'(dv[2]),
                       cent[0], cent[1], cent[2], 32'(2 * m + $urandom_range(0, 255)),
                       $urandom >> $urandom_range(1, 31), 1'($urandom_range(1)));
            return r;
        end
        scale = longint'(1) << $urandom_range(12, 18);
        for (k = 0; k < 3; k++)
        begin
            dv[k] = longint'($urandom_range(0, 32'(scale))) - scale / 2;
            if (m != 0)
                dv[k] = dv[k] - (off[k] * scale) / m;
            if (sel >= 85)
                dv[k] = -dv[k];
        end
        r = ray_of(cent[0] + 32'(off[0]), cent[1] + 32'(off[1]), cent[2] + 32'(off[2]),
                   32'(dv[0]), 32'(dv[1]), 32'(dv[2]), cent[0], cent[1], cent[2],
                   32'((longint'($urandom_range(0, 1023)) * m) >> 10),
                   32'((longint'($urandom_range(0, 4095)) * m) >> 10),
                   1'($urandom_range(1)));
        return r;
    endfunction

    // Present one ray and hold it until the block takes it. Called at an
    // edge where the previous ray was just transferred; each cycle before
    // the new ray idles with a chance of 29 in 100 when may_idle is set, so start drops there.
    task automatic send_ray(input ray_item_t r, input bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(99) < 29)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        on_bus <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        on_bus = ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: surface, inside, zero direction, tangent and near miss,
        // length limit on both sides, pointing away, and field extremes.
        send_ray(ray_of(ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(0, 0, 0, 0, 0, 0, ONE, ONE, 0, 4 * ONE, 0, 1'b1), 1'b1);
        send_ray(ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(-(10 * ONE), ONE, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(-(10 * ONE), ONE, 0, ONE, 0, 0, 0, 0, 0, ONE - 1, 0, 1'b0), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 1'b1), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 20 * ONE, 1'b1), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 5 * ONE, 1'b1), 1'b1);
        send_ray(ray_of(-(10 * ONE), 0, 0, -ONE, 0, 0, 0, 0, 0, ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(0, -(10 * ONE), 0, 0, 3 * ONE, 0, 0, 0, 0, 2 * ONE, 0, 1'b0), 1'b1);
        send_ray(ray_of(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS,
                        MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 1'b1), 1'b1);
        send_ray(ray_of(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                        MIN_NEG, MIN_NEG, MIN_NEG, 0, 0, 1'b0), 1'b1);
        send_ray(ray_of(MAX_POS, MAX_POS, MAX_POS, MIN_NEG, MIN_NEG, MIN_NEG,
                        MIN_NEG, MIN_NEG, MIN_NEG, 0, 0, 1'b0), 1'b1);
        send_ray(ray_of(MIN_NEG, MIN_NEG, MIN_NEG, MAX_POS, MAX_POS, MAX_POS,
                        MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 1'b1), 1'b1);
        send_ray(ray_of(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                        MAX_POS, MAX_POS, MAX_POS, MAX_POS, 0, 1'b0), 1'b1);
        send_ray(ray_of(MAX_POS, MAX_POS, MAX_POS, MIN_NEG, MIN_NEG, MIN_NEG,
                        MIN_NEG, MIN_NEG, MIN_NEG, MAX_POS, 0, 1'b1), 1'b1);
        send_ray(ray_of(MAX_POS, 0, MIN_NEG, MIN_NEG, 0, MAX_POS,
                        0, 0, 0, ONE, MAX_POS, 1'b1), 1'b1);
        send_ray(ray_of(MAX_POS, MIN_NEG, 0, MIN_NEG, MAX_POS, MIN_NEG,
                        MIN_NEG, MAX_POS, 0, MAX_POS, MAX_POS, 1'b0), 1'b1);

        // Random: a stretch in the middle runs back to back with no gaps.
        for (i = 0; i < RANDOM_RAYS; i++)
            send_ray(random_ray(), !(i >= 200 && i < 350));
        start <= 1'b0;

        // Drain the pipeline, then watch a little longer for stray strobes.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (RSH_LATENCY + 3) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/rsh_pkg.sv
sv/rsh_wide_square.sv
sv/ray_sphere_hit_test_top.sv
sv/rsh_checker.sv
sim/ray_sphere_hit_test_top_test.sv
